FILE: hw/rtl/nnu_pkg.sv
// Shared types and constants for the nearest-neighbor upscaler.
package nnu_pkg;

	localparam int SCALE_W = 4;   // scale register width
	localparam int WIDTH_W = 11;  // width_pixels register width
	localparam int COL_W   = 14;  // output column and line length width
	localparam int REP_W   = 3;   // pixel repeat counter width
	localparam int RUN_W   = 7;   // outputs per input transaction, up to 64
	localparam int PIX_W   = 24;
	localparam int CFG_W   = 11;  // widest register

	localparam logic REG_SCALE = 1'b0;
	localparam logic REG_WIDTH = 1'b1;

	// Effective (clamped) configuration seen by the sequencer.
	typedef struct packed {
		logic [SCALE_W-1:0] scale;
		logic [WIDTH_W-1:0] width;
	} nnu_cfg_t;

endpackage

FILE: hw/rtl/nnu_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module nnu_div import nnu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [COL_W-1:0]   dividend,
	input  logic [SCALE_W-1:0] divisor,
	output logic               done,
	output logic [COL_W-1:0]   quotient,
	output logic [SCALE_W-1:0] remainder
);

	localparam int CNT_W = $clog2(COL_W + 1);

	logic [COL_W-1:0]   quo_q;
	logic [SCALE_W-1:0] rem_q;
	logic [SCALE_W-1:0] div_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               done_q;
	logic [SCALE_W:0]   trial;
	logic               ge;

	assign trial = {rem_q, quo_q[COL_W-1]};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(COL_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[COL_W-2:0], ge};
			rem_q <= ge ? SCALE_W'(trial - {1'b0, div_q}) : SCALE_W'(trial);
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

FILE: hw/rtl/nnu_line_mem.sv
// Double line buffer: two banks of source pixels, one write and one read port.
module nnu_line_mem import nnu_pkg::*; #(
	parameter int AW    = 10,
	parameter int DEPTH = 2048
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW:0]      waddr,
	input  logic [PIX_W-1:0] wdata,
	input  logic             re,
	input  logic [AW:0]      raddr,
	output logic [PIX_W-1:0] rdata
);

	logic [PIX_W-1:0] mem [DEPTH];
	logic [PIX_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/nnu_ctrl.sv
// Sequencer: row bookkeeping, replay of the previous row and output flags.
module nnu_ctrl import nnu_pkg::*; #(
	parameter int AW = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  nnu_cfg_t         cfg,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             kind,
	output logic             mem_we,
	output logic [AW:0]      mem_waddr,
	output logic             mem_re,
	output logic [AW:0]      mem_raddr,
	output logic             div_start,
	output logic [COL_W-1:0] div_dividend,
	input  logic             div_done,
	input  logic [COL_W-1:0] div_quotient,
	input  logic [SCALE_W-1:0] div_remainder,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             line_end,
	output logic [1:0]       pad_bytes,
	output logic             last
);

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_EMIT, ST_FIN} state_t;

	state_t             state_q;
	logic               wbank_q;
	logic               prev_valid_q;
	logic               row_pix_q;
	logic [WIDTH_W-1:0] in_col_q;
	logic [COL_W-1:0]   out_col_q;
	logic [COL_W-1:0]   src_q;
	logic [REP_W-1:0]   rep_q;
	logic [RUN_W-1:0]   cnt_q;
	logic               out_valid_q;
	logic               line_end_q;
	logic [1:0]         pad_q;
	logic               last_q;

	logic               accept;
	logic               issue;
	logic [COL_W-1:0]   line_len;
	logic [COL_W-1:0]   width_ext;
	logic [COL_W-1:0]   src_sat;
	logic [RUN_W-1:0]   run_len;
	logic               endl;
	logic               run_last;

	assign accept    = in_valid && (state_q == ST_IDLE);
	assign in_stall  = (state_q != ST_IDLE);
	assign issue     = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);

	assign width_ext = COL_W'(cfg.width);
	assign line_len  = width_ext * COL_W'(cfg.scale);
	assign run_len   = RUN_W'(cfg.scale) * RUN_W'(cfg.scale);
	assign endl      = out_col_q >= (line_len - 1'b1);
	assign run_last  = cnt_q == (run_len - 1'b1);
	// A replayed column past the row end sticks at the last pixel.
	assign src_sat   = (src_q >= width_ext) ? (width_ext - 1'b1) : src_q;

	assign mem_we       = accept && !kind;
	assign mem_waddr    = {wbank_q, AW'(in_col_q)};
	assign mem_re       = issue;
	assign mem_raddr    = {~wbank_q, AW'(src_sat)};
	assign div_start    = accept && prev_valid_q;
	assign div_dividend = out_col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			wbank_q      <= 1'b0;
			prev_valid_q <= 1'b0;
			row_pix_q    <= 1'b0;
			in_col_q     <= '0;
			out_col_q    <= '0;
			src_q        <= '0;
			rep_q        <= '0;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
			line_end_q   <= 1'b0;
			pad_q        <= '0;
			last_q       <= 1'b0;
		end else begin
			if (issue) begin
				out_valid_q <= 1'b1;
				line_end_q  <= endl;
				pad_q       <= endl ? line_len[1:0] : 2'b00;
				last_q      <= run_last;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (!kind) begin
							row_pix_q <= 1'b1;
						end
						state_q <= prev_valid_q ? ST_DIV : ST_FIN;
					end
				end
				ST_DIV: begin
					// Split the output column into source pixel and repeat phase.
					if (div_done) begin
						src_q   <= div_quotient;
						rep_q   <= REP_W'(div_remainder);
						cnt_q   <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (issue) begin
						cnt_q <= cnt_q + 1'b1;
						if (endl) begin
							out_col_q <= '0;
							src_q     <= '0;
							rep_q     <= '0;
						end else begin
							out_col_q <= out_col_q + 1'b1;
							if (rep_q >= REP_W'(cfg.scale - 1'b1)) begin
								rep_q <= '0;
								src_q <= src_q + 1'b1;
							end else begin
								rep_q <= rep_q + 1'b1;
							end
						end
						if (run_last) begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					if (in_col_q >= cfg.width - 1'b1) begin
						wbank_q      <= ~wbank_q;
						prev_valid_q <= row_pix_q;
						row_pix_q    <= 1'b0;
						in_col_q     <= '0;
						out_col_q    <= '0;
					end else begin
						in_col_q <= in_col_q + 1'b1;
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign line_end  = line_end_q;
	assign pad_bytes = pad_q;
	assign last      = last_q;

endmodule

FILE: hw/rtl/nearest_neighbor_upscaler.sv
// Nearest-neighbor integer upscaler for 24-bit pixels, top level.
//
// Source pixels enter on the input channel (in_valid/in_stall) row by row,
// kind 0 for a pixel and kind 1 for a blank slot that only advances the
// row position. Each input transaction replays the next scale*scale output
// pixels of the previous row on the output channel (out_valid/out_stall),
// so output lags input by one row; a row of blanks drains the last row.
// line_end marks the last pixel of an output line and pad_bytes then gives
// (width_pixels*scale) mod 4. last marks the final output of a transaction.
// A transaction with a previous row to replay runs the bit-serial divider
// that maps the output column to a source pixel, then does one line buffer
// read per output pixel and the row bookkeeping. Without a row to replay it
// only does the row bookkeeping. in_stall is high for the whole transaction.
// When the receiver stalls, the registered output holds and replay pauses.
// Reset clears the sequencer and sets scale and width_pixels to 1; the
// line buffer is not cleared. Write configuration only while idle.
module nearest_neighbor_upscaler import nnu_pkg::*; #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_SCALE = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             kind,
	input  logic [7:0]       blue_in,
	input  logic [7:0]       green_in,
	input  logic [7:0]       red_in,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       blue_out,
	output logic [7:0]       green_out,
	output logic [7:0]       red_out,
	output logic             line_end,
	output logic [1:0]       pad_bytes,
	output logic             last
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	logic [SCALE_W-1:0] scale_q;
	logic [WIDTH_W-1:0] width_q;
	nnu_cfg_t           cfg;

	logic               mem_we;
	logic [AW:0]        mem_waddr;
	logic               mem_re;
	logic [AW:0]        mem_raddr;
	logic [PIX_W-1:0]   rdata;
	logic               div_start;
	logic [COL_W-1:0]   div_dividend;
	logic               div_done;
	logic [COL_W-1:0]   div_quotient;
	logic [SCALE_W-1:0] div_remainder;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_W'(1);
			width_q <= WIDTH_W'(1);
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_SCALE: scale_q <= cfg_data[SCALE_W-1:0];
				REG_WIDTH: width_q <= cfg_data[WIDTH_W-1:0];
				default: ;
			endcase
		end
	end

	// Out-of-range settings are clamped into the supported range.
	always_comb begin
		if (scale_q == '0) begin
			cfg.scale = SCALE_W'(1);
		end else if (32'(scale_q) > 32'(MAX_SCALE)) begin
			cfg.scale = SCALE_W'(MAX_SCALE);
		end else begin
			cfg.scale = scale_q;
		end
		if (width_q == '0) begin
			cfg.width = WIDTH_W'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			cfg.width = WIDTH_W'(MAX_WIDTH);
		end else begin
			cfg.width = width_q;
		end
	end

	nnu_ctrl #(.AW(AW)) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_re       (mem_re),
		.mem_raddr    (mem_raddr),
		.div_start    (div_start),
		.div_dividend (div_dividend),
		.div_done     (div_done),
		.div_quotient (div_quotient),
		.div_remainder(div_remainder),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.line_end     (line_end),
		.pad_bytes    (pad_bytes),
		.last         (last)
	);

	nnu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (cfg.scale),
		.done     (div_done),
		.quotient (div_quotient),
		.remainder(div_remainder)
	);

	// Each bank spans the full column address range, so the depth follows AW.
	nnu_line_mem #(.AW(AW), .DEPTH(2 << AW)) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata({red_in, green_in, blue_in}),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(rdata)
	);

	assign blue_out  = rdata[7:0];
	assign green_out = rdata[15:8];
	assign red_out   = rdata[23:16];

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the nearest-neighbor upscaler: directed and random pixel rows.
module testbench;
	import nnu_pkg::*;

	localparam int MAX_COLS = 1024;
	localparam int COL_BITS = $clog2(MAX_COLS);
	localparam int TOP_SCALE = 8;
	localparam int SETTLE = 120;       // covers the divider, a full 64-pixel replay and bookkeeping
	localparam int LONG_HOLD = 300;
	localparam int WATCHDOG = 4000;
	localparam int TARGET_ITEMS = 380;
	localparam int QUIET_ITEMS = 340;  // from here on neither side idles
	localparam logic PIXEL = 1'b0;
	localparam logic BLANK = 1'b1;

	typedef struct packed {
		logic       blank;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} src_item_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic       line_end;
		logic [1:0] pad;
		logic       last;
	} out_pixel_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_write = 1'b0;
	logic             cfg_index = REG_SCALE;
	logic [CFG_W-1:0] cfg_data = '0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic             kind = PIXEL;
	logic [7:0]       blue_in = 8'h00;
	logic [7:0]       green_in = 8'h00;
	logic [7:0]       red_in = 8'h00;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [7:0]       blue_out;
	logic [7:0]       green_out;
	logic [7:0]       red_out;
	logic             line_end;
	logic [1:0]       pad_bytes;
	logic             last;

	nearest_neighbor_upscaler #(
		.MAX_WIDTH(MAX_COLS),
		.MAX_SCALE(TOP_SCALE)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.blue_in(blue_in),
		.green_in(green_in),
		.red_in(red_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.blue_out(blue_out),
		.green_out(green_out),
		.red_out(red_out),
		.line_end(line_end),
		.pad_bytes(pad_bytes),
		.last(last)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Upscaler state as the testbench sees it.
	logic [23:0]  line_mem [0:1][0:MAX_COLS-1];
	logic         wr_bank = 1'b0;
	logic         replay_armed = 1'b0;
	logic         row_seen_pixel = 1'b0;
	int unsigned  fill_col = 0;
	int unsigned  rep_col = 0;
	logic [3:0]   scale_reg;
	logic [10:0]  width_reg;

	src_item_t    pending_src[$];
	out_pixel_t   expected_out[$];
	src_item_t    cur_src;
	out_pixel_t   seen_px;
	out_pixel_t   want_px;

	int unsigned  items_queued;
	int unsigned  items_taken;
	int unsigned  blanks_taken = 0;
	int unsigned  pixels_checked = 0;
	int unsigned  error_count = 0;
	int unsigned  phase_count;
	int unsigned  gap_left;
	int unsigned  stall_left;
	int unsigned  hold_left;
	int unsigned  hold_requests;
	int unsigned  holds_served;
	int unsigned  quiet_cycles = 0;
	bit           send_idle_on;
	bit           recv_idle_on;

	function automatic int unsigned clamp_scale(logic [3:0] v);
		if (v == 0)
			return 1;
		if (32'(v) > TOP_SCALE)
			return TOP_SCALE;
		return 32'(v);
	endfunction

	function automatic int unsigned clamp_width(logic [10:0] v);
		if (v == 0)
			return 1;
		if (32'(v) > MAX_COLS)
			return MAX_COLS;
		return 32'(v);
	endfunction

	// Replays scale*scale pixels of the previous row if one is armed, then stores the new pixel unless it is blank.
	function automatic void upscale_item(src_item_t it);
		int unsigned s;
		int unsigned w;
		int unsigned line_len;
		int unsigned src;
		int unsigned n;
		logic        rd;
		logic        endl;
		out_pixel_t  px;
		s = clamp_scale(scale_reg);
		w = clamp_width(width_reg);
		line_len = w * s;
		rd = ~wr_bank;
		if (replay_armed) begin
			for (n = 0; n < s * s; n++) begin
				endl = (rep_col >= line_len - 1);
				src = rep_col / s;
				if (src >= w)
					src = w - 1;
				px.red = line_mem[rd][COL_BITS'(src)][23:16];
				px.green = line_mem[rd][COL_BITS'(src)][15:8];
				px.blue = line_mem[rd][COL_BITS'(src)][7:0];
				px.line_end = endl;
				px.pad = endl ? 2'(line_len % 4) : 2'd0;
				px.last = (n == s * s - 1);
				expected_out.push_back(px);
				rep_col = endl ? 0 : rep_col + 1;
			end
		end
		if (it.blank == PIXEL) begin
			line_mem[wr_bank][COL_BITS'(fill_col)] = {it.red, it.green, it.blue};
			row_seen_pixel = 1'b1;
		end
		if (fill_col >= w - 1) begin
			wr_bank = ~wr_bank;
			replay_armed = row_seen_pixel;
			row_seen_pixel = 1'b0;
			fill_col = 0;
			rep_col = 0;
		end else begin
			fill_col++;
		end
	endfunction

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (idx == REG_SCALE)
			scale_reg = val[3:0];
		else
			width_reg = val[10:0];
	endtask

	task automatic push_src(input logic blank, input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		src_item_t it;
		it.blank = blank;
		it.red = r;
		it.green = g;
		it.blue = b;
		pending_src.push_back(it);
		items_queued++;
	endtask

	task automatic push_rand(input logic blank);
		push_src(blank, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)));
	endtask

	// Blocks until every queued transaction is in and its output has arrived.
	task automatic wait_idle();
		while (items_taken != items_queued || expected_out.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Source side driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			kind <= PIXEL;
			blue_in <= 8'h00;
			green_in <= 8'h00;
			red_in <= 8'h00;
			gap_left <= 0;
			items_taken <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				upscale_item(cur_src);
				items_taken <= items_taken + 1;
				if (cur_src.blank == BLANK)
					blanks_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_src.size() != 0 && send_idle_on &&
						$urandom_range(0, 5) == 0) begin
					gap_left <= $urandom_range(0, 8);
					in_valid <= 1'b0;
				end else if (pending_src.size() != 0) begin
					cur_src = pending_src.pop_front();
					kind <= cur_src.blank;
					red_in <= cur_src.red;
					green_in <= cur_src.green;
					blue_in <= cur_src.blue;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output side: check each transaction and decide the stall for the next cycle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
			hold_left <= 0;
			holds_served <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				seen_px.blue = blue_out;
				seen_px.green = green_out;
				seen_px.red = red_out;
				seen_px.line_end = line_end;
				seen_px.pad = pad_bytes;
				seen_px.last = last;
				pixels_checked++;
				if (expected_out.size() == 0) begin
					error_count++;
					if (error_count <= 10)
						$display("unexpected output pixel b=%h g=%h r=%h end=%b pad=%0d last=%b",
							seen_px.blue, seen_px.green, seen_px.red, seen_px.line_end,
							seen_px.pad, seen_px.last);
				end else begin
					want_px = expected_out.pop_front();
					if (seen_px.blue !== want_px.blue || seen_px.green !== want_px.green ||
							seen_px.red !== want_px.red || seen_px.line_end !== want_px.line_end ||
							seen_px.pad !== want_px.pad || seen_px.last !== want_px.last) begin
						error_count++;
						if (error_count <= 10)
							$display({"output pixel %0d mismatch: expected b=%h g=%h r=%h end=%b ",
								"pad=%0d last=%b, got b=%h g=%h r=%h end=%b pad=%0d last=%b"},
								pixels_checked, want_px.blue, want_px.green, want_px.red,
								want_px.line_end, want_px.pad, want_px.last, seen_px.blue,
								seen_px.green, seen_px.red, seen_px.line_end, seen_px.pad,
								seen_px.last);
					end
				end
			end
			if (holds_served != hold_requests) begin
				holds_served <= hold_requests;
				hold_left <= LONG_HOLD - 1;
				out_stall <= 1'b1;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_stall <= 1'b1;
			end else if (recv_idle_on && $urandom_range(0, 5) == 0) begin
				stall_left <= $urandom_range(0, 8);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Ends the run if neither channel moves a transaction for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG) begin
				$display("testbench: FAIL");
				$finish;
			end
		end
	end

	initial begin
		logic [3:0]  cs;
		logic [10:0] cw;
		int unsigned w_eff;
		int unsigned col;
		int unsigned rows;
		int unsigned max_rows;
		int unsigned r;
		bit          all_blank;
		bit          row_done;
		bit          late;

		scale_reg = 4'd1;
		width_reg = 11'd1;
		items_queued = 0;
		phase_count = 0;
		hold_requests = 0;
		send_idle_on = 1'b1;
		recv_idle_on = 1'b1;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Zero registers act as one. The first row has nothing to replay, then an
		// all-blank row leaves nothing behind it.
		write_reg(REG_SCALE, 0);
		write_reg(REG_WIDTH, 0);
		push_src(PIXEL, 8'h00, 8'h00, 8'h00);
		push_src(PIXEL, 8'hff, 8'hff, 8'hff);
		push_src(BLANK, 8'hff, 8'h00, 8'hff);
		push_src(BLANK, 8'h00, 8'hff, 8'h00);
		wait_idle();

		// Oversized scale acts as the maximum; a blank row flushes the last one.
		write_reg(REG_SCALE, 15);
		write_reg(REG_WIDTH, 3);
		push_src(PIXEL, 8'haa, 8'h55, 8'haa);
		push_src(PIXEL, 8'h55, 8'haa, 8'h55);
		push_rand(PIXEL);
		repeat (3) push_rand(PIXEL);
		repeat (3) push_rand(BLANK);
		wait_idle();

		// Width changes in the middle of rows, both shrinking and growing.
		write_reg(REG_SCALE, 3);
		write_reg(REG_WIDTH, 1024);
		repeat (2) push_rand(PIXEL);
		wait_idle();
		write_reg(REG_WIDTH, 1);
		push_rand(PIXEL);
		wait_idle();
		write_reg(REG_SCALE, 2);
		write_reg(REG_WIDTH, 3);
		repeat (2) push_rand(PIXEL);
		wait_idle();
		write_reg(REG_WIDTH, 2047);
		push_rand(PIXEL);
		wait_idle();
		write_reg(REG_WIDTH, 1);
		push_rand(PIXEL);
		wait_idle();
		push_rand(BLANK);
		wait_idle();

		// Two full rows at width 64 so that blanks and width changes later on
		// only ever replay columns that hold a pixel.
		write_reg(REG_SCALE, 1);
		write_reg(REG_WIDTH, 64);
		repeat (128) push_rand(PIXEL);
		wait_idle();

		while (items_queued < TARGET_ITEMS) begin
			phase_count++;
			case ($urandom_range(0, 9))
				0: cw = 11'd0;
				1: cw = 11'd64;
				2, 3: cw = 11'($urandom_range(17, 63));
				default: cw = 11'($urandom_range(1, 16));
			endcase
			case ($urandom_range(0, 9))
				0: cs = 4'd0;
				1: cs = 4'($urandom_range(9, 15));
				default: cs = 4'($urandom_range(1, 8));
			endcase
			write_reg(REG_SCALE, CFG_W'(cs));
			write_reg(REG_WIDTH, cw);
			w_eff = clamp_width(cw);
			late = (items_queued >= QUIET_ITEMS);
			send_idle_on = !late && ($urandom_range(0, 3) != 0);
			recv_idle_on = !late && ($urandom_range(0, 3) != 0);
			// The first random phase starts with a replayable row: hold the output
			// off while the source keeps offering so the block backs up.
			if (phase_count == 1) begin
				send_idle_on = 1'b0;
				hold_requests++;
			end
			max_rows = 40 / w_eff;
			if (max_rows < 1)
				max_rows = 1;
			if (max_rows > 4)
				max_rows = 4;
			rows = $urandom_range(1, max_rows);
			col = fill_col;
			for (r = 0; r < rows; r++) begin
				all_blank = ($urandom_range(0, 9) == 0);
				row_done = 1'b0;
				while (!row_done) begin
					push_rand((all_blank || $urandom_range(0, 9) == 0) ? BLANK : PIXEL);
					row_done = (col >= w_eff - 1);
					col = row_done ? 0 : col + 1;
				end
			end
			// Sometimes stop inside a row so the next setting lands mid-row.
			if (w_eff > 1 && $urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, w_eff - 1)) push_rand(PIXEL);
			wait_idle();
		end

		while (items_taken != items_queued)
			@(posedge clk);
		while (expected_out.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display({"covered %0d source transactions (%0d blank) and %0d output pixels ",
			"in %0d random phases"}, items_taken, blanks_taken, pixels_checked, phase_count);
		$display({"including scale 0..15, width 0..2047, mid-row width changes ",
			"and a %0d-cycle output hold"}, LONG_HOLD);
		if (error_count == 0 && expected_out.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
